// ===== src/btrm_pkg.sv =====
// Shared types, constants and helpers for the binned transfer rate meter.
// No dependencies; every other file refers to it by scoped names.
package btrm_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned BYTES_W = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SPEED_W = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Defaults
  localparam int unsigned BINS_DEFAULT = 10;
  localparam logic [CFG_W-1:0] RESET_INTERVAL    = 16'd2000;
  localparam logic [CFG_W-1:0] RESET_GRANULARITY = 16'd200;

  // Divider: quotient bits retired per cycle
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_ITERS     = BYTES_W / DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_ITERS);

  // Operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRANULARITY = 1'b1;

  // One ring entry
  typedef struct packed {
    logic [TIME_W-1:0]  start;
    logic [BYTES_W-1:0] bytes;
  } bin_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [BYTES_W-1:0] dividend;
    logic [CFG_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SPEED_W-1:0] quotient;
  } div_rsp_t;

  // Multiply by 1000 modulo 2^64: 1024 - 32 + 8
  function automatic logic [BYTES_W-1:0] scale_1000(input logic [BYTES_W-1:0] v);
    scale_1000 = (v << 10) - (v << 5) + (v << 3);
  endfunction

endpackage

// ===== src/btrm_bin_ram.sv =====
// Ring storage for the time bins: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses btrm_pkg.
module btrm_bin_ram #(
  parameter int unsigned DEPTH  = btrm_pkg::BINS_DEFAULT,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  btrm_pkg::bin_t     wr_data_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output btrm_pkg::bin_t     rd_data_o
);

  btrm_pkg::bin_t mem [DEPTH];
  btrm_pkg::bin_t rd_word_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_word_q <= mem[rd_addr_i];
  end

  // Track written entries, register the read's valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // Unwritten entries read as zero
  assign rd_data_o = rd_valid_q ? rd_word_q : '0;

endmodule

// ===== src/btrm_div.sv =====
// Iterative 64 by 16 bit unsigned divider, DIV_STEP_BITS quotient bits a cycle.
// Returns the low 32 quotient bits, zero for a zero divisor. Uses btrm_pkg.
module btrm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btrm_pkg::div_req_t  req_i,
  output btrm_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned DW = btrm_pkg::BYTES_W;
  localparam int unsigned RW = btrm_pkg::CFG_W;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [btrm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]                 dq_q, dq_d;
  logic [RW-1:0]                 rem_q, rem_d;
  logic [RW-1:0]                 dvsr_q;
  logic                          zero_q;
  logic [DW-1:0]                 dq_s;
  logic [RW-1:0]                 rem_s;
  logic [RW:0]                   trial;
  logic                          ge;

  // Retire several quotient bits by restoring subtraction
  always_comb begin
    dq_s  = dq_q;
    rem_s = rem_q;
    trial = '0;
    ge    = 1'b0;
    for (int b = 0; b < btrm_pkg::DIV_STEP_BITS; b++) begin
      trial = {rem_s, dq_s[DW-1]};
      ge    = trial >= {1'b0, dvsr_q};
      rem_s = ge ? RW'(trial - {1'b0, dvsr_q}) : trial[RW-1:0];
      dq_s  = {dq_s[DW-2:0], ge};
    end
  end

  // Sequence the iterations
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = req_i.dividend;
      rem_d  = '0;
    end else if (busy_q) begin
      dq_d  = dq_s;
      rem_d = rem_s;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == btrm_pkg::DIV_CNT_W'(btrm_pkg::DIV_ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      dvsr_q <= req_i.divisor;
      zero_q <= (req_i.divisor == '0);
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = zero_q ? '0 : dq_q[btrm_pkg::SPEED_W-1:0];

endmodule

// ===== src/binned_transfer_rate_meter_core.sv =====
// Sliding-window transfer rate meter over a ring of BINS time bins held in a
// single-port-write, registered-read memory. A record word reads the newest
// bin, then writes it back or opens the next one. A query that hits the cache
// goes straight to the response; otherwise it does one memory read per visited
// bin, the x1000 scaling, then the 4-bit-per-cycle divider, and a handoff to
// the output register. One word is processed at a time; a finished result
// waits in the output register while the next word is accepted.
module binned_transfer_rate_meter_core #(
  parameter int unsigned BINS = btrm_pkg::BINS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [btrm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [btrm_pkg::CFG_W-1:0]        cfg_data_i,
  // Input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [btrm_pkg::TIME_W-1:0]       now_ms_i,
  input  logic [btrm_pkg::COUNT_W-1:0]      byte_count_i,
  // Result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [btrm_pkg::SPEED_W-1:0]      speed_bps_o
);

  localparam int unsigned IDX_W = $clog2(BINS);
  localparam int unsigned CNT_W = $clog2(BINS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BINS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REC  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_RESP = 3'd5;

  localparam int unsigned TW = btrm_pkg::TIME_W;
  localparam int unsigned BW = btrm_pkg::BYTES_W;

  logic [2:0]                   state_q, state_d;
  logic [btrm_pkg::CFG_W-1:0]   interval_q, granularity_q;
  logic [IDX_W-1:0]             newest_q, newest_d;
  logic [IDX_W-1:0]             walk_idx_q, walk_idx_d;
  logic [CNT_W-1:0]             walk_cnt_q, walk_cnt_d;
  logic [BW-1:0]                sum_q, sum_d;
  logic [TW-1:0]                cutoff_q, cutoff_d;
  logic [TW-1:0]                now_q;
  logic [btrm_pkg::COUNT_W-1:0] bytes_q;
  logic                         cache_valid_q, cache_valid_d;
  logic [TW-1:0]                cached_time_q, cached_time_d;
  logic [btrm_pkg::SPEED_W-1:0] cached_speed_q, cached_speed_d;
  logic [btrm_pkg::SPEED_W-1:0] result_q, result_d;
  logic                         out_valid_q, out_valid_d;
  logic [btrm_pkg::SPEED_W-1:0] out_data_q, out_data_d;

  logic                         accept;
  logic [TW:0]                  now_minus_int;
  logic [TW:0]                  bin_limit;
  logic                         cache_hit;
  logic [IDX_W-1:0]             prev_idx, next_newest;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  btrm_pkg::bin_t               wr_data;
  logic [IDX_W-1:0]             rd_addr;
  btrm_pkg::bin_t               rd_data;
  btrm_pkg::div_req_t           div_req;
  btrm_pkg::div_rsp_t           div_rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= btrm_pkg::RESET_INTERVAL;
      granularity_q <= btrm_pkg::RESET_GRANULARITY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btrm_pkg::REG_INTERVAL:    interval_q    <= cfg_data_i;
        btrm_pkg::REG_GRANULARITY: granularity_q <= cfg_data_i;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Window cutoff; top bit is the borrow when now precedes the interval
  assign now_minus_int = {1'b0, now_ms_i} - {{(TW + 1 - btrm_pkg::CFG_W){1'b0}}, interval_q};
  assign cache_hit     = cache_valid_q && (cached_time_q == now_ms_i);

  // Newest bin still open until start + granularity
  assign bin_limit   = {1'b0, rd_data.start}
                     + {{(TW + 1 - btrm_pkg::CFG_W){1'b0}}, granularity_q};
  assign next_newest = (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;
  assign prev_idx    = (walk_idx_q == '0) ? LAST_IDX : walk_idx_q - 1'b1;

  // Sequencer
  always_comb begin
    state_d        = state_q;
    newest_d       = newest_q;
    walk_idx_d     = walk_idx_q;
    walk_cnt_d     = walk_cnt_q;
    sum_d          = sum_q;
    cutoff_d       = cutoff_q;
    cache_valid_d  = cache_valid_q;
    cached_time_d  = cached_time_q;
    cached_speed_d = cached_speed_q;
    result_d       = result_q;
    rd_addr        = newest_q;
    wr_en          = 1'b0;
    wr_addr        = newest_q;
    wr_data        = rd_data;
    div_req.start    = 1'b0;
    div_req.dividend = btrm_pkg::scale_1000(sum_q);
    div_req.divisor  = interval_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          walk_idx_d = newest_q;
          walk_cnt_d = '0;
          sum_d      = '0;
          cutoff_d   = now_minus_int[TW-1:0];
          if (operation_i == btrm_pkg::OP_RECORD) begin
            state_d = ST_REC;
          end else if (cache_hit) begin
            result_d = cached_speed_q;
            state_d  = ST_RESP;
          end else if (now_minus_int[TW]) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_REC: begin
        // Add to the open bin or open the next one
        wr_en = 1'b1;
        if (bin_limit >= {1'b0, now_q}) begin
          wr_addr       = newest_q;
          wr_data.start = rd_data.start;
          wr_data.bytes = rd_data.bytes + BW'(bytes_q);
        end else begin
          wr_addr       = next_newest;
          wr_data.start = now_q;
          wr_data.bytes = BW'(bytes_q);
          newest_d      = next_newest;
        end
        cache_valid_d = 1'b0;
        state_d       = ST_IDLE;
      end
      ST_WALK: begin
        // Sum bins newer than the cutoff, one read a cycle
        rd_addr = prev_idx;
        if (walk_cnt_q == CNT_W'(BINS) || rd_data.start <= cutoff_q) begin
          state_d = ST_MUL;
        end else begin
          sum_d      = sum_q + rd_data.bytes;
          walk_cnt_d = walk_cnt_q + 1'b1;
          walk_idx_d = prev_idx;
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          result_d       = div_rsp.quotient;
          cached_speed_d = div_rsp.quotient;
          cached_time_d  = now_q;
          cache_valid_d  = 1'b1;
          state_d        = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load a finished result, drop a taken one
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_RESP && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_data_d  = result_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      newest_q       <= '0;
      walk_idx_q     <= '0;
      walk_cnt_q     <= '0;
      cache_valid_q  <= 1'b0;
      cached_time_q  <= '0;
      cached_speed_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      newest_q       <= newest_d;
      walk_idx_q     <= walk_idx_d;
      walk_cnt_q     <= walk_cnt_d;
      cache_valid_q  <= cache_valid_d;
      cached_time_q  <= cached_time_d;
      cached_speed_q <= cached_speed_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    cutoff_q   <= cutoff_d;
    result_q   <= result_d;
    out_data_q <= out_data_d;
    if (accept) begin
      now_q   <= now_ms_i;
      bytes_q <= byte_count_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign speed_bps_o = out_data_q;

  btrm_bin_ram #(
    .DEPTH  (BINS),
    .ADDR_W (IDX_W)
  ) u_bin_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  btrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Checks
  a_newest_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    newest_q <= LAST_IDX)
    else $error("newest bin index outside the ring");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_cnt_q <= CNT_W'(BINS))
    else $error("query walk went past one full turn");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == ST_DIV)
    else $error("divider running outside its state");

  a_record_clears_cache: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == btrm_pkg::OP_RECORD) |=> ##1 !cache_valid_q)
    else $error("record word left the cached speed valid");

endmodule
